[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger, outside reset.
`define CHK_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[hdl/lffs_pkg.sv]
`default_nettype none

package lffs_pkg;

  // Input request: a start request or a time tick.
  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
    logic [7:0]  flash_count;
    logic        restore_defaults;
    logic        lamp_on;
    logic [15:0] present_lightness;
    logic [15:0] present_temperature;
    logic [15:0] saved_lightness;
    logic [15:0] saved_temperature;
  } item_t;

  // Result request, one per tick.
  typedef struct packed {
    logic [15:0] drive_lightness;
    logic [15:0] drive_temperature;
    logic        finished;
  } result_t;

  // Per-tick values that ride along the fade pipeline.
  typedef struct packed {
    logic        fin;
    logic [15:0] fin_level;
    logic [15:0] temp;
    logic [15:0] start_level;
    logic [15:0] end_level;
  } ctl_t;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Register select, taken from the word address bit.
  localparam logic REG_DEF_LIGHT = 1'b0;
  localparam logic REG_DEF_TEMP  = 1'b1;

  localparam logic [15:0] LIGHT_RESET = 16'd65535;
  localparam logic [14:0] TEMP_RESET  = 15'd20000;

  // Fade timing in milliseconds.
  localparam int PERIOD_MS = 1000;
  localparam int FADE_MS   = 600;
  localparam int RAMP_MS   = 400;
  localparam int SPAN_W    = 18;

  // Residue modulo one period: 10-bit chunks, 2^10 mod 1000 = 24.
  localparam int CHUNK_W    = 10;
  localparam int CHUNK_WRAP = 24;
  localparam int SUM_W      = 23;
  localparam int FOLD1_W    = 18;
  localparam int FOLD2_W    = 13;
  localparam int FOLD3_W    = 11;
  localparam int RES_W      = 10;

  // Scaling: level = base * num / 400 or / 600 via reciprocal multiply.
  localparam int PROD_W        = 26;
  localparam int Y_W           = 23;
  localparam int RECIP_W       = 24;
  localparam int PRE_SHIFT_400 = 4;
  localparam int PRE_SHIFT_600 = 3;
  localparam int SHIFT_400     = 26;
  localparam int SHIFT_600     = 30;
  localparam logic [RECIP_W-1:0] RECIP_400 = 24'd2684355;
  localparam logic [RECIP_W-1:0] RECIP_600 = 24'd14316558;

  // Weight of chunk i of a time difference, modulo one period.
  function automatic logic [CHUNK_W-1:0] chunk_weight(input int unsigned i);
    int unsigned w;
    int unsigned k;
    w = 1;
    for (k = 0; k < i; k++) begin
      w = (w * CHUNK_WRAP) % 1000;
    end
    return CHUNK_W'(w);
  endfunction

endpackage

`default_nettype wire

[hdl/led_flash_fade_sequencer.sv]
`default_nettype none
// Lamp flash and fade sequencer.
// Input channel (item, item_valid, item_stall): a start request latches the
// sequence levels, temperatures and end time and gives no result; a tick
// request carries the time in ms and gives exactly one result request.
// Output channel (result, result_valid, result_stall): the lightness and
// temperature to drive, and finished once the end time is reached.
// Configuration: APB-style writes set the default lightness (address 0) and
// default temperature (address 4); pready is always high.
// Pipeline: a tick passes through the input register, time difference,
// chunked modulo (three stages), level multiply and reciprocal divide
// before its result shows.
// Throughput: one request per cycle unless result_stall backs up the
// pipeline. item_stall is a registered skid flag, so it rises in the cycle after
// the pipeline backs up and one extra request is held in the skid register.
// A stalled result holds; earlier stages keep filling until they are full.
// Reset (rst, synchronous) clears all sequence state, empties the pipeline
// and restores the default lightness and temperature; a tick before any
// start reports finished with zero lightness and temperature.

module led_flash_fade_sequencer
  import lffs_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_stall,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [15:0] default_lightness;
  logic [14:0] default_temperature;
  logic [15:0] def_temp16;

  // Sequence state.
  logic [15:0]           start_level;
  logic [15:0]           target_level;
  logic [15:0]           running_temperature;
  logic [15:0]           target_temperature;
  logic [TIME_WIDTH-1:0] end_time;

  // Input register and skid buffer.
  item_t s0;
  item_t skid;
  logic  v0;
  logic  skid_v;
  logic  accept;
  logic  drain0;
  logic  rdy0;
  logic  is_start;

  // Pipeline valids, readies and control payload.
  logic [6:1] v;
  logic [6:1] rdy;
  ctl_t       ctl [1:5];
  ctl_t       ctl1_next;

  // Start and tick arithmetic on the input register.
  logic [TIME_WIDTH+31:0] now_wide;
  logic [TIME_WIDTH-1:0]  now_t;
  logic [SPAN_W-1:0]      span;
  logic [TIME_WIDTH-1:0]  end_on;
  logic [TIME_WIDTH-1:0]  end_off;
  logic [TIME_WIDTH:0]    diff;
  logic [TIME_WIDTH-1:0]  d_next;
  logic [TIME_WIDTH-1:0]  d1;
  logic                   fin;
  logic                   near;
  logic [15:0]            st_level;
  logic [15:0]            st_run_t;
  logic [15:0]            st_tgt_l;
  logic [15:0]            st_tgt_t;
  logic [TIME_WIDTH-1:0]  st_end;

  // Fade level arithmetic.
  logic [RES_W-1:0]          r4;
  logic                      sel_next;
  logic [RES_W-1:0]          num;
  logic [15:0]               base;
  logic [PROD_W-1:0]         p5;
  logic                      sel5;
  logic [Y_W-1:0]            y;
  logic [RECIP_W-1:0]        recip;
  logic [Y_W+RECIP_W-1:0]    quot_prod;
  logic [15:0]               level;

  assign pready     = 1'b1;
  assign def_temp16 = {1'b0, default_temperature};

  // Configuration write and read.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_lightness   <= LIGHT_RESET;
      default_temperature <= TEMP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_DEF_LIGHT: default_lightness   <= pwdata[15:0];
        REG_DEF_TEMP:  default_temperature <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEF_LIGHT: prdata = {16'd0, default_lightness};
      REG_DEF_TEMP:  prdata = {17'd0, default_temperature};
      default:       prdata = '0;
    endcase
  end

  // Ready chain from the output register back to the input register.
  always_comb begin
    rdy[6] = !v[6] || !result_stall;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign is_start   = (s0.mode == MODE_START);
  assign drain0     = v0 && (is_start || rdy[1]);
  assign rdy0       = !v0 || drain0;
  assign item_stall = skid_v;
  assign accept     = item_valid && !skid_v;

  // Input register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= skid_v || accept;
      end
      if (rdy0) begin
        skid_v <= 1'b0;
      end else if (accept) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0 <= skid_v ? skid : item;
    end
    if (accept && !rdy0) begin
      skid <= item;
    end
  end

  // Time of the request, fitted to the time width.
  assign now_wide = {{TIME_WIDTH{1'b0}}, s0.now_ms};
  assign now_t    = now_wide[TIME_WIDTH-1:0];
  assign span     = SPAN_W'(s0.flash_count) * SPAN_W'(PERIOD_MS);
  assign end_on   = now_t + TIME_WIDTH'(span);
  assign end_off  = end_on - TIME_WIDTH'(RAMP_MS);

  // Start request: pick levels and temperatures by lamp state.
  always_comb begin
    if (s0.lamp_on) begin
      st_level = (s0.present_lightness != '0) ? s0.present_lightness : default_lightness;
      st_run_t = (s0.present_temperature != '0) ? s0.present_temperature : def_temp16;
      st_tgt_l = s0.restore_defaults ? default_lightness : st_level;
      st_end   = end_on;
    end else begin
      st_level = (s0.saved_lightness != '0 && !s0.restore_defaults) ?
                 s0.saved_lightness : default_lightness;
      st_run_t = (s0.saved_temperature != '0) ? s0.saved_temperature : def_temp16;
      st_tgt_l = st_level;
      st_end   = end_off;
    end
    st_tgt_t = s0.restore_defaults ? def_temp16 : st_run_t;
  end

  // Tick request: remaining time, end check and near-end check.
  always_comb begin
    diff   = {1'b0, end_time} - {1'b0, now_t};
    d_next = diff[TIME_WIDTH-1:0];
    fin    = diff[TIME_WIDTH] || (d_next == '0);
    near   = d_next < TIME_WIDTH'(PERIOD_MS);

    ctl1_next.fin         = fin;
    ctl1_next.fin_level   = target_level;
    ctl1_next.start_level = start_level;
    ctl1_next.end_level   = near ? target_level : start_level;
    if (fin || near) begin
      ctl1_next.temp = target_temperature;
    end else begin
      ctl1_next.temp = running_temperature;
    end
  end

  // Sequence state update as a request leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_level         <= '0;
      target_level        <= '0;
      running_temperature <= '0;
      target_temperature  <= '0;
      end_time            <= '0;
    end else if (drain0) begin
      if (is_start) begin
        start_level         <= st_level;
        target_level        <= st_tgt_l;
        running_temperature <= st_run_t;
        target_temperature  <= st_tgt_t;
        end_time            <= st_end;
      end else if (!fin && near) begin
        running_temperature <= target_temperature;
      end
    end
  end

  // Pipeline valids; only ticks enter the fade pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= v0 && (s0.mode == MODE_TICK);
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Control payload rides along with the valids.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ctl[1] <= ctl1_next;
      d1     <= d_next;
    end
    for (int k = 2; k <= 5; k++) begin
      if (rdy[k]) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // Remaining time modulo one period, three stages.
  lffs_residue #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_residue (
    .clk (clk),
    .en  ({rdy[4], rdy[3], rdy[2]}),
    .d   (d1),
    .r   (r4)
  );

  // Ramp-up or fade-down numerator and its product with the level.
  always_comb begin
    sel_next = r4 > RES_W'(FADE_MS);
    if (sel_next) begin
      num  = r4 - RES_W'(FADE_MS);
      base = ctl[4].start_level;
    end else begin
      num  = RES_W'(FADE_MS) - r4;
      base = ctl[4].end_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      p5   <= PROD_W'(base) * PROD_W'(num);
      sel5 <= sel_next;
    end
  end

  // Divide by 400 or 600 through an exact reciprocal multiply.
  always_comb begin
    if (sel5) begin
      y     = Y_W'(p5 >> PRE_SHIFT_400);
      recip = RECIP_400;
    end else begin
      y     = Y_W'(p5 >> PRE_SHIFT_600);
      recip = RECIP_600;
    end
    quot_prod = (Y_W+RECIP_W)'(y) * (Y_W+RECIP_W)'(recip);
    if (sel5) begin
      level = 16'(quot_prod >> SHIFT_400);
    end else begin
      level = 16'(quot_prod >> SHIFT_600);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      result.finished          <= ctl[5].fin;
      result.drive_temperature <= ctl[5].temp;
      result.drive_lightness   <= ctl[5].fin ? ctl[5].fin_level : level;
    end
  end

  assign result_valid = v[6];

  `include "assert_macros.svh"

  // The skid entry is only filled behind an occupied input register.
  `CHK_ALWAYS(a_skid_behind_input, !skid_v || v0, "skid full with empty input register")

  // The running temperature only moves when a request leaves the input register.
  `CHK_NEXT(a_temp_only_on_drain, !drain0, $stable(running_temperature), "temperature moved without a request")

  // The residue unit always delivers a value below one period.
  `CHK_ALWAYS(a_residue_range, !v[4] || (r4 < RES_W'(PERIOD_MS)), "residue out of range")

endmodule

`default_nettype wire

[hdl/lffs_residue.sv]
`default_nettype none

module lffs_residue
  import lffs_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [TIME_WIDTH-1:0] d,
  output logic [RES_W-1:0]      r
);

  localparam int NCH = (TIME_WIDTH + CHUNK_W - 1) / CHUNK_W;

  logic [NCH*CHUNK_W-1:0] dpad;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       sum;
  logic [FOLD1_W-1:0]     fold1;
  logic [FOLD2_W-1:0]     fold_next;
  logic [FOLD2_W-1:0]     fold;
  logic [FOLD3_W-1:0]     fold3;
  logic [RES_W-1:0]       r_next;

  assign dpad = (NCH*CHUNK_W)'(d);

  // Weighted sum of the chunks, each weight reduced modulo one period.
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NCH; i++) begin
      sum_next = sum_next + SUM_W'(dpad[i*CHUNK_W +: CHUNK_W]) * SUM_W'(chunk_weight(i));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum <= sum_next;
    end
  end

  // Two folds of the upper bits back onto the low chunk.
  assign fold1 = FOLD1_W'(sum[SUM_W-1:CHUNK_W]) * FOLD1_W'(CHUNK_WRAP)
               + FOLD1_W'(sum[CHUNK_W-1:0]);
  assign fold_next = FOLD2_W'(fold1[FOLD1_W-1:CHUNK_W]) * FOLD2_W'(CHUNK_WRAP)
                   + FOLD2_W'(fold1[CHUNK_W-1:0]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fold <= fold_next;
    end
  end

  // Last fold leaves a value below two periods; one subtract finishes it.
  always_comb begin
    fold3 = FOLD3_W'(fold[FOLD2_W-1:CHUNK_W]) * FOLD3_W'(CHUNK_WRAP)
          + FOLD3_W'(fold[CHUNK_W-1:0]);
    if (fold3 >= FOLD3_W'(PERIOD_MS)) begin
      r_next = RES_W'(fold3 - FOLD3_W'(PERIOD_MS));
    end else begin
      r_next = RES_W'(fold3);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r <= r_next;
    end
  end

endmodule

`default_nettype wire

[sim/flash_fade_check.sv]
// Watches both request channels and the register port, predicts each tick's
// drive values and compares them with what the block sends out.
module flash_fade_check
  import lffs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  input  logic        item_stall,
  input  result_t     result,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          checked
);

  // Register copies and the latched flash sequence.
  logic [15:0] dflt_light;
  logic [14:0] dflt_temp;
  logic [15:0] start_level;
  logic [15:0] target_level;
  logic [15:0] run_temp;
  logic [15:0] target_temp;
  logic [31:0] end_ms;

  // Drive values still owed by the block, oldest first.
  result_t drive_expected[$];

  // A start request latches levels, temperatures and the end time.
  function automatic void latch_sequence(item_t r);
    logic [15:0] temp_dflt;
    temp_dflt = {1'b0, dflt_temp};
    if (r.lamp_on) begin
      start_level  = (r.present_lightness != 0) ? r.present_lightness : dflt_light;
      run_temp     = (r.present_temperature != 0) ? r.present_temperature : temp_dflt;
      target_level = r.restore_defaults ? dflt_light : start_level;
      target_temp  = r.restore_defaults ? temp_dflt : run_temp;
      end_ms       = r.now_ms + 32'(r.flash_count) * 32'(PERIOD_MS);
    end else begin
      start_level  = (r.saved_lightness != 0 && !r.restore_defaults) ?
                     r.saved_lightness : dflt_light;
      target_level = start_level;
      run_temp     = (r.saved_temperature != 0) ? r.saved_temperature : temp_dflt;
      target_temp  = r.restore_defaults ? temp_dflt : run_temp;
      end_ms       = r.now_ms + 32'(r.flash_count) * 32'(PERIOD_MS) - 32'(RAMP_MS);
    end
  endfunction

  // Drive values for a tick at the given time. Inside the last period the
  // running temperature settles on the target.
  function automatic result_t fade_at(logic [31:0] now);
    result_t     o;
    logic [31:0] d;
    logic [15:0] end_level;
    logic [47:0] lvl;
    if (now >= end_ms) begin
      o.drive_lightness   = target_level;
      o.drive_temperature = target_temp;
      o.finished          = 1'b1;
    end else begin
      d = end_ms - now;
      if (d < PERIOD_MS) begin
        end_level = target_level;
        run_temp  = target_temp;
      end else begin
        end_level = start_level;
        d         = d % PERIOD_MS;
      end
      if (d > FADE_MS) begin
        lvl = 48'(start_level) * 48'(d - FADE_MS) / 48'(RAMP_MS);
      end else begin
        lvl = 48'(end_level) * 48'(FADE_MS - d) / 48'(FADE_MS);
      end
      o.drive_lightness   = lvl[15:0];
      o.drive_temperature = run_temp;
      o.finished          = 1'b0;
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      dflt_light   = LIGHT_RESET;
      dflt_temp    = TEMP_RESET;
      start_level  = '0;
      target_level = '0;
      run_temp     = '0;
      target_temp  = '0;
      end_ms       = '0;
      drive_expected.delete();
      errors       = 0;
      checked      = 0;
    end else begin
      // Register writes only happen while the block is idle.
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_DEF_LIGHT: dflt_light = pwdata[15:0];
          REG_DEF_TEMP:  dflt_temp  = pwdata[14:0];
          default: ;
        endcase
      end
      // A result leaving now belongs to an older request than one entering now.
      if (result_valid && !result_stall) begin
        if (drive_expected.size() == 0) begin
          $error("result with no tick request outstanding");
          errors++;
        end else begin
          want = drive_expected.pop_front();
          check_field("drive_lightness", want.drive_lightness, result.drive_lightness);
          check_field("drive_temperature", want.drive_temperature,
                      result.drive_temperature);
          check_field("finished", 16'(want.finished), 16'(result.finished));
          checked++;
        end
      end
      if (item_valid && !item_stall) begin
        if (item.mode == MODE_START) begin
          latch_sequence(item);
        end else begin
          drive_expected.push_back(fade_at(item.now_ms));
        end
      end
    end
    pending = drive_expected.size();
  end

endmodule

[sim/tb_led_flash_fade_sequencer.sv]
module tb_led_flash_fade_sequencer;
  import lffs_pkg::*;

  localparam logic [2:0] ADDR_LIGHT = 3'd0;
  localparam logic [2:0] ADDR_TEMP  = 3'd4;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 245;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst;
  item_t       item;
  logic        item_valid;
  logic        item_stall;
  result_t     result;
  logic        result_valid;
  logic        result_stall;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int checked;
  int n_start = 0;
  int n_tick = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  bit idling = 1'b1;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  led_flash_fade_sequencer dut (
    .clk, .rst, .item, .item_valid, .item_stall, .result, .result_valid,
    .result_stall, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  flash_fade_check fade_chk (
    .clk, .rst, .item, .item_valid, .item_stall, .result, .result_valid,
    .result_stall, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .checked
  );

  // A request with every field random.
  function automatic item_t noise();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  // A tick request; the fields a tick ignores stay random.
  function automatic item_t tick_at(logic [31:0] now);
    item_t r;
    r        = noise();
    r.mode   = MODE_TICK;
    r.now_ms = now;
    return r;
  endfunction

  function automatic item_t start_req(logic [31:0] now, logic [7:0] count, logic restore,
                                      logic lamp, logic [15:0] pl, logic [15:0] pt,
                                      logic [15:0] sl, logic [15:0] st);
    item_t r;
    r.mode                = MODE_START;
    r.now_ms              = now;
    r.flash_count         = count;
    r.restore_defaults    = restore;
    r.lamp_on             = lamp;
    r.present_lightness   = pl;
    r.present_temperature = pt;
    r.saved_lightness     = sl;
    r.saved_temperature   = st;
    return r;
  endfunction

  // Zero stands for "none stored" or "use default", so it is made common.
  function automatic logic [15:0] maybe_zero(logic [15:0] v);
    return ($urandom_range(0, 3) == 0) ? 16'd0 : v;
  endfunction

  // Offer one request and hold it until accepted, then maybe leave a gap.
  task automatic send(item_t r);
    item       <= r;
    item_valid <= 1'b1;
    if (r.mode == MODE_START) n_start++;
    else n_tick++;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  // Stop offering and let the block finish everything it holds.
  task automatic settle();
    item_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly a start followed by ticks spread over the sequence and around its
  // end time; now and then a request with random content.
  task automatic burst(int quota, bit allow_idle);
    int          stop;
    int          n;
    item_t       s;
    logic [31:0] due;
    logic [31:0] now;
    logic [31:0] off;
    stop = n_start + n_tick + quota;
    while (n_start + n_tick < stop) begin
      if (allow_idle) idling = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        send(noise());
      end else begin
        s      = noise();
        s.mode = MODE_START;
        if ($urandom_range(0, 3) == 0) s.now_ms = $urandom_range(0, 3000);
        if ($urandom_range(0, 3) != 0) s.flash_count = $urandom_range(0, 4);
        s.present_lightness   = maybe_zero(s.present_lightness);
        s.present_temperature = maybe_zero(s.present_temperature);
        s.saved_lightness     = maybe_zero(s.saved_lightness);
        s.saved_temperature   = maybe_zero(s.saved_temperature);
        due = s.now_ms + 32'(s.flash_count) * 32'd1000 - (s.lamp_on ? 32'd0 : 32'd400);
        send(s);
        n = $urandom_range(2, 14);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0: begin
              case ($urandom_range(0, 3))
                0: off = $urandom_range(0, 2);
                1: off = $urandom_range(598, 602);
                2: off = $urandom_range(998, 1002);
                default: off = $urandom_range(1, 999);
              endcase
              now = due - off;
            end
            1: now = due + $urandom_range(0, 2000);
            default: now = s.now_ms + $urandom_range(0, s.flash_count * 1000 + 600);
          endcase
          send(tick_at(now));
        end
      end
    end
  endtask

  // Receiver: random stall bursts, or one long hold-off when asked for.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no request moves on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[led_flash_fade_sequencer] ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] light_val;
    logic [31:0] temp_val;
    rst        = 1'b1;
    item       = '0;
    item_valid = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests under the reset defaults.
    // Ticks before any start see the cleared state.
    send(tick_at(32'd0));
    send(tick_at(32'hFFFF_FFFF));
    // Lamp on, two flashes: walk the fade and ramp boundaries of both periods.
    send(start_req(32'd1000, 8'd2, 1'b0, 1'b1, 16'd40000, 16'd5000, 16'd0, 16'd0));
    send(tick_at(32'd1000));
    send(tick_at(32'd1400));
    send(tick_at(32'd1399));
    send(tick_at(32'd2000));
    send(tick_at(32'd2001));
    send(tick_at(32'd2400));
    send(tick_at(32'd2999));
    send(tick_at(32'd3000));
    // Lamp on with nothing present and defaults restored.
    send(start_req(32'd5000, 8'd1, 1'b1, 1'b1, 16'd0, 16'd0, 16'd7, 16'd9));
    send(tick_at(32'd5100));
    send(tick_at(32'd6000));
    // Lamp off with no flashes: the end time wraps far ahead.
    send(start_req(32'd100, 8'd0, 1'b0, 1'b0, 16'd3, 16'd4, 16'd30000, 16'd3000));
    send(tick_at(32'd200));
    send(tick_at(32'hFFFF_FFFF));
    // Lamp off, defaults restored over a stored level.
    send(start_req(32'd0, 8'd3, 1'b1, 1'b0, 16'd0, 16'd0, 16'd1234, 16'd0));
    send(tick_at(32'd1000));
    send(tick_at(32'd2599));
    // All fields but the time at their maximum; the end time wraps past zero.
    send(start_req(32'hFFFF_FF00, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF));
    send(tick_at(32'hFFFF_FF00));
    send(tick_at(32'd10));
    // Lamp off with nothing stored.
    send(start_req(32'd50000, 8'd1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    send(tick_at(32'd50000));
    settle();

    // Random phases, each under its own default settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin light_val = 32'd0;     temp_val = 32'd800;   end
        1: begin light_val = 32'd65535; temp_val = 32'd32767; end
        2: begin light_val = 32'd1;     temp_val = 32'd20000; end
        5: begin light_val = 32'd65535; temp_val = 32'd0;     end
        default: begin light_val = $urandom; temp_val = $urandom; end
      endcase
      write_reg(ADDR_LIGHT, light_val);
      write_reg(ADDR_TEMP, temp_val);
      n_settings++;
      idling = (p != PHASES - 1);
      if (p == 2) begin
        burst(PHASE_ITEMS / 2, 1'b1);
        // Back the block up: the receiver holds off while ticks keep coming.
        idling   = 1'b0;
        hold_req = 1'b1;
        repeat (40) send(tick_at($urandom));
        wait (!hold_req);
        burst(PHASE_ITEMS / 2, 1'b1);
      end else begin
        burst(PHASE_ITEMS, p != PHASES - 1);
      end
      settle();
    end

    $display("Sent %0d requests (%0d starts, %0d ticks), checked %0d results.",
             n_start + n_tick, n_start, n_tick, checked);
    $display("Covered %0d default settings, random stalls, and one long output hold-off.",
             n_settings);
    if (errors == 0) begin
      $display("[led_flash_fade_sequencer] OK");
    end else begin
      $display("[led_flash_fade_sequencer] ERROR");
    end
    $finish;
  end

endmodule
